FILE: hw/rtl/dispersion_tensor_from_velocity_macros.svh
// assertion macros for the dispersion tensor block
// used by the top level only, no other dependencies
`ifndef DISPERSION_TENSOR_FROM_VELOCITY_MACROS_SVH
`define DISPERSION_TENSOR_FROM_VELOCITY_MACROS_SVH

// property checked outside reset
`define DTV_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dtv check failed");

// property checked at every edge, reset included
`define DTV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("dtv check failed");

`endif

FILE: hw/rtl/dtv_pkg.sv
// shared types and constants of the dispersion tensor pipeline
// no dependencies
package dtv_pkg;

  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 32;
  localparam int LANES       = 6;

  localparam logic [1:0] REG_ALPHA_L  = 2'd0;
  localparam logic [1:0] REG_ALPHA_TV = 2'd1;
  localparam logic [1:0] REG_ALPHA_TH = 2'd2;

  localparam int W_XX = 0;
  localparam int W_YY = 1;
  localparam int W_ZZ = 2;
  localparam int W_XY = 3;
  localparam int W_XZ = 4;
  localparam int W_YZ = 5;

  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [16:0] sat;
    logic        nxy;
    logic        nxz;
    logic        nyz;
    logic        bad;
    logic        zero;
  } side_t;

  typedef logic [LANES-1:0][63:0] dvd_t;
  typedef logic [LANES-1:0][33:0] quot_t;

endpackage

FILE: hw/rtl/dtv_sqrt.sv
// pipelined integer square root, two result bits per stage
// depends on dtv_pkg
module dtv_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_rad,
  input  dtv_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [32:0]     out_root,
  output dtv_pkg::side_t  out_side
);

  localparam int STAGES = dtv_pkg::SQRT_STAGES;

  logic           v  [STAGES];
  logic [63:0]    x  [STAGES];
  logic [63:0]    r  [STAGES];
  dtv_pkg::side_t sd [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT_A = 64'd1 << (62 - 4 * k);
    localparam logic [63:0] BIT_B = 64'd1 << (60 - 4 * k);
    logic           pv;
    logic [63:0]    px, pr, xa, ra, xb, rb;
    dtv_pkg::side_t ps;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign px = in_rad;
      assign pr = '0;
      assign ps = in_side;
    end else begin : g_next
      assign pv = v[k-1];
      assign px = x[k-1];
      assign pr = r[k-1];
      assign ps = sd[k-1];
    end

    always_comb begin
      if (px >= pr + BIT_A) begin
        xa = px - (pr + BIT_A);
        ra = (pr >> 1) + BIT_A;
      end else begin
        xa = px;
        ra = pr >> 1;
      end
      if (xa >= ra + BIT_B) begin
        xb = xa - (ra + BIT_B);
        rb = (ra >> 1) + BIT_B;
      end else begin
        xb = xa;
        rb = ra >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[k]  <= xb;
        r[k]  <= rb;
        sd[k] <= ps;
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign out_root  = r[STAGES-1][32:0];
  assign out_side  = sd[STAGES-1];

endmodule

FILE: hw/rtl/dtv_div.sv
// six-lane pipelined restoring divider, two quotient bits per stage
// depends on dtv_pkg
module dtv_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  dtv_pkg::dvd_t   in_dvd,
  input  logic [32:0]     in_dvs,
  input  dtv_pkg::side_t  in_side,
  output logic            out_valid,
  output dtv_pkg::quot_t  out_quot,
  output dtv_pkg::side_t  out_side
);

  localparam int STAGES = dtv_pkg::DIV_STAGES;
  localparam int LANES  = dtv_pkg::LANES;

  logic                        v   [STAGES];
  dtv_pkg::dvd_t               dvd [STAGES];
  logic [32:0]                 dvs [STAGES];
  logic [LANES-1:0][32:0]      rem [STAGES];
  dtv_pkg::quot_t              quo [STAGES];
  dtv_pkg::side_t              sd  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int BA = 63 - 2 * k;
    localparam int BB = 62 - 2 * k;
    logic                   pv;
    dtv_pkg::dvd_t          pd;
    logic [32:0]            pn;
    logic [LANES-1:0][32:0] prem, rem_n;
    dtv_pkg::quot_t         pq, q_n;
    dtv_pkg::side_t         ps;

    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign pd   = in_dvd;
      assign pn   = in_dvs;
      assign prem = '0;
      assign pq   = '0;
      assign ps   = in_side;
    end else begin : g_next
      assign pv   = v[k-1];
      assign pd   = dvd[k-1];
      assign pn   = dvs[k-1];
      assign prem = rem[k-1];
      assign pq   = quo[k-1];
      assign ps   = sd[k-1];
    end

    always_comb begin
      logic [33:0] ta, tb;
      logic [32:0] ra;
      logic [33:0] qa;
      for (int l = 0; l < LANES; l++) begin
        ta = {prem[l], pd[l][BA]};
        if (ta >= {1'b0, pn}) begin
          ra = 33'(ta - {1'b0, pn});
          qa = {pq[l][32:0], 1'b1};
        end else begin
          ra = ta[32:0];
          qa = {pq[l][32:0], 1'b0};
        end
        tb = {ra, pd[l][BB]};
        if (tb >= {1'b0, pn}) begin
          rem_n[l] = 33'(tb - {1'b0, pn});
          q_n[l]   = {qa[32:0], 1'b1};
        end else begin
          rem_n[l] = tb[32:0];
          q_n[l]   = {qa[32:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd[k] <= pd;
        dvs[k] <= pn;
        rem[k] <= rem_n;
        quo[k] <= q_n;
        sd[k]  <= ps;
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign out_quot  = quo[STAGES-1];
  assign out_side  = sd[STAGES-1];

endmodule

FILE: hw/rtl/dispersion_tensor_from_velocity.sv
// top level of the mechanical dispersion tensor pipeline
// depends on dtv_pkg, dtv_sqrt, dtv_div and the assertion macro header
//
// Usage:
// - input channel in_valid / in_stall carries one cell: Darcy velocity
//   vel_x, vel_y, vel_z (signed Q16.16), saturation and porosity (Q1.16)
// - output channel out_valid / out_stall carries the six distinct tensor
//   components (signed Q16.16, saturated) and the bad_porosity flag
// - dispersivities are written through wr_en / wr_index / wr_data
//   (0 longitudinal, 1 vertical transverse, 2 horizontal transverse)
//   while the pipeline is empty
// - one transaction per cycle is accepted while in_stall is low; the path
//   runs through the 16-stage square root and the 32-stage divider
// - the whole pipeline advances together; when a result is held by
//   out_stall, in_stall rises and every stage keeps its contents
// - reset empties the pipeline and clears the dispersivities to zero
// - with DIMENSION = 2, vel_z is ignored and d_zz, d_xz, d_yz are zero
`include "dispersion_tensor_from_velocity_macros.svh"
module dispersion_tensor_from_velocity #(
  parameter int DIMENSION = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic [16:0]        saturation,
  input  logic [16:0]        porosity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] d_xx,
  output logic signed [31:0] d_yy,
  output logic signed [31:0] d_zz,
  output logic signed [31:0] d_xy,
  output logic signed [31:0] d_xz,
  output logic signed [31:0] d_yz,
  output logic               bad_porosity,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data
);

  localparam logic THREE = (DIMENSION == 3);
  localparam int   LANES = dtv_pkg::LANES;

  function automatic logic [63:0] sat64(input logic [66:0] val);
    return (|val[66:64]) ? '1 : val[63:0];
  endfunction

  function automatic logic [31:0] fin(input logic [49:0] val, input logic neg);
    if (!neg) begin
      return (val > 50'h7FFFFFFF) ? 32'h7FFFFFFF : val[31:0];
    end
    return (val >= 50'h80000000) ? 32'h80000000 : 32'(-val[31:0]);
  endfunction

  // configuration
  logic [31:0] alpha_l, alpha_tv, alpha_th;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_l  <= '0;
      alpha_tv <= '0;
      alpha_th <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        dtv_pkg::REG_ALPHA_L:  alpha_l  <= wr_data;
        dtv_pkg::REG_ALPHA_TV: alpha_tv <= wr_data;
        dtv_pkg::REG_ALPHA_TH: alpha_th <= wr_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: magnitudes and signs
  logic           s1_valid;
  dtv_pkg::side_t s1_side;
  logic [31:0]    vz_eff;
  assign vz_eff = THREE ? vel_z : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.ux   <= vel_x[31] ? 32'(-vel_x) : vel_x;
      s1_side.uy   <= vel_y[31] ? 32'(-vel_y) : vel_y;
      s1_side.uz   <= vz_eff[31] ? 32'(-vz_eff) : vz_eff;
      s1_side.sat  <= saturation;
      s1_side.nxy  <= vel_x[31] ^ vel_y[31];
      s1_side.nxz  <= vel_x[31] ^ vz_eff[31];
      s1_side.nyz  <= vel_y[31] ^ vz_eff[31];
      s1_side.bad  <= (porosity == 17'd0);
      s1_side.zero <= 1'b0;
    end
  end

  // stage 2: squares
  logic           s2_valid;
  dtv_pkg::side_t s2_side;
  logic [63:0]    s2_xx, s2_yy, s2_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_xx   <= 64'(s1_side.ux) * 64'(s1_side.ux);
      s2_yy   <= 64'(s1_side.uy) * 64'(s1_side.uy);
      s2_zz   <= 64'(s1_side.uz) * 64'(s1_side.uz);
      s2_side <= s1_side;
    end
  end

  // stage 3: squared norm
  logic           s3_valid;
  dtv_pkg::side_t s3_side, s3_side_next;
  logic [63:0]    s3_norm2, norm2;
  assign norm2 = s2_xx + s2_yy + s2_zz;

  always_comb begin
    s3_side_next      = s2_side;
    s3_side_next.zero = (norm2 == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_norm2 <= norm2;
      s3_side  <= s3_side_next;
    end
  end

  // square root
  logic           q_valid;
  logic [32:0]    q_root;
  dtv_pkg::side_t q_side;

  dtv_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_rad    (s3_norm2),
    .in_side   (s3_side),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  // products of velocity components
  logic                   p_valid;
  dtv_pkg::side_t         p_side;
  logic [32:0]            p_root;
  logic [LANES-1:0][63:0] p_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod[dtv_pkg::W_XX] <= 64'(q_side.ux) * 64'(q_side.ux);
      p_prod[dtv_pkg::W_YY] <= 64'(q_side.uy) * 64'(q_side.uy);
      p_prod[dtv_pkg::W_ZZ] <= 64'(q_side.uz) * 64'(q_side.uz);
      p_prod[dtv_pkg::W_XY] <= 64'(q_side.ux) * 64'(q_side.uy);
      p_prod[dtv_pkg::W_XZ] <= 64'(q_side.ux) * 64'(q_side.uz);
      p_prod[dtv_pkg::W_YZ] <= 64'(q_side.uy) * 64'(q_side.uz);
      p_root <= q_root;
      p_side <= q_side;
    end
  end

  // dividends with half-divisor rounding
  logic           d_valid;
  dtv_pkg::side_t d_side;
  logic [32:0]    d_root;
  dtv_pkg::dvd_t  d_dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        d_dvd[l] <= p_prod[l] + 64'(p_root[32:1]);
      end
      d_root <= p_root;
      d_side <= p_side;
    end
  end

  // divider
  logic           w_valid;
  dtv_pkg::quot_t w;
  dtv_pkg::side_t w_side;

  dtv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_dvd    (d_dvd),
    .in_dvs    (d_root),
    .in_side   (d_side),
    .out_valid (w_valid),
    .out_quot  (w),
    .out_side  (w_side)
  );

  // dispersivity products
  logic        c1_neg, c2_neg;
  logic [31:0] c1, c2;
  assign c1_neg = alpha_l < alpha_th;
  assign c1     = c1_neg ? alpha_th - alpha_l : alpha_l - alpha_th;
  assign c2_neg = alpha_l < alpha_tv;
  assign c2     = c2_neg ? alpha_tv - alpha_l : alpha_l - alpha_tv;

  logic           m_valid;
  dtv_pkg::side_t m_side;
  logic [66:0]    m_l_xx, m_h_yy, m_v_zz, m_l_yy, m_h_xx, m_l_zz, m_v_xy;
  logic [66:0]    m_c_xy, m_c_xz, m_c_yz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_l_xx <= 67'(alpha_l)  * 67'(w[dtv_pkg::W_XX]);
      m_h_yy <= 67'(alpha_th) * 67'(w[dtv_pkg::W_YY]);
      m_v_zz <= 67'(alpha_tv) * 67'(w[dtv_pkg::W_ZZ]);
      m_l_yy <= 67'(alpha_l)  * 67'(w[dtv_pkg::W_YY]);
      m_h_xx <= 67'(alpha_th) * 67'(w[dtv_pkg::W_XX]);
      m_l_zz <= 67'(alpha_l)  * 67'(w[dtv_pkg::W_ZZ]);
      m_v_xy <= 67'(alpha_tv) * (67'(w[dtv_pkg::W_XX]) + 67'(w[dtv_pkg::W_YY]));
      m_c_xy <= 67'(c1) * 67'(w[dtv_pkg::W_XY]);
      m_c_xz <= 67'(c2) * 67'(w[dtv_pkg::W_XZ]);
      m_c_yz <= 67'(c2) * 67'(w[dtv_pkg::W_YZ]);
      m_side <= w_side;
    end
  end

  // saturated sums
  logic                   a_valid;
  dtv_pkg::side_t         a_side;
  logic [LANES-1:0][63:0] a_mag;
  logic [LANES-1:0]       a_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag[dtv_pkg::W_XX] <= sat64(67'(sat64(m_l_xx)) + 67'(sat64(m_h_yy))
                                    + 67'(sat64(m_v_zz)));
      a_mag[dtv_pkg::W_YY] <= sat64(67'(sat64(m_l_yy)) + 67'(sat64(m_h_xx))
                                    + 67'(sat64(m_v_zz)));
      a_mag[dtv_pkg::W_ZZ] <= sat64(67'(sat64(m_l_zz)) + 67'(sat64(m_v_xy)));
      a_mag[dtv_pkg::W_XY] <= sat64(m_c_xy);
      a_mag[dtv_pkg::W_XZ] <= sat64(m_c_xz);
      a_mag[dtv_pkg::W_YZ] <= sat64(m_c_yz);
      a_neg[dtv_pkg::W_XX] <= 1'b0;
      a_neg[dtv_pkg::W_YY] <= 1'b0;
      a_neg[dtv_pkg::W_ZZ] <= 1'b0;
      a_neg[dtv_pkg::W_XY] <= c1_neg ^ m_side.nxy;
      a_neg[dtv_pkg::W_XZ] <= c2_neg ^ m_side.nxz;
      a_neg[dtv_pkg::W_YZ] <= c2_neg ^ m_side.nyz;
      a_side <= m_side;
    end
  end

  // saturation scaling
  logic                   f_valid;
  dtv_pkg::side_t         f_side;
  logic [LANES-1:0][49:0] f_r;
  logic [LANES-1:0]       f_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        f_r[l] <= 50'(a_mag[l][63:32]) * 50'(a_side.sat)
                  + 50'((50'(a_mag[l][31:0]) * 50'(a_side.sat) + 50'h80000000) >> 32);
      end
      f_neg  <= a_neg;
      f_side <= a_side;
    end
  end

  // output register
  logic force_zero, three_zero;
  assign force_zero = f_side.bad || f_side.zero;
  assign three_zero = force_zero || !THREE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_xx <= force_zero ? 32'sd0 : fin(f_r[dtv_pkg::W_XX], f_neg[dtv_pkg::W_XX]);
      d_yy <= force_zero ? 32'sd0 : fin(f_r[dtv_pkg::W_YY], f_neg[dtv_pkg::W_YY]);
      d_xy <= force_zero ? 32'sd0 : fin(f_r[dtv_pkg::W_XY], f_neg[dtv_pkg::W_XY]);
      d_zz <= three_zero ? 32'sd0 : fin(f_r[dtv_pkg::W_ZZ], f_neg[dtv_pkg::W_ZZ]);
      d_xz <= three_zero ? 32'sd0 : fin(f_r[dtv_pkg::W_XZ], f_neg[dtv_pkg::W_XZ]);
      d_yz <= three_zero ? 32'sd0 : fin(f_r[dtv_pkg::W_YZ], f_neg[dtv_pkg::W_YZ]);
      bad_porosity <= f_side.bad;
    end
  end

  `DTV_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `DTV_ASSERT(a_bad_zero, clk, rst, out_valid && bad_porosity |-> d_xx == 0 && d_yy == 0
              && d_zz == 0 && d_xy == 0 && d_xz == 0 && d_yz == 0)
  `DTV_ASSERT(a_diag_pos, clk, rst, out_valid |-> !d_xx[31] && !d_yy[31] && !d_zz[31])
  `DTV_ASSERT(a_planar, clk, rst, out_valid && !THREE |-> d_zz == 0 && d_xz == 0 && d_yz == 0)

endmodule
